// ----- hw/rtl/sbsi_pkg.sv -----
// sbsi_pkg: shared types and codes for the segment/box slab intersect block
// no dependencies; imported by sbsi_prep, sbsi_div, sbsi_hit and the top module
package sbsi_pkg;

    // normal component codes, two bit signed
    localparam logic [1:0] NRM_ZERO = 2'b00;
    localparam logic [1:0] NRM_POS  = 2'b01;
    localparam logic [1:0] NRM_NEG  = 2'b11;

    // per axis control decided in the prep stage
    typedef struct packed {
        logic reject;    // segment wholly outside the slab
        logic dir_pos;   // segment moves toward +axis
        logic need_min;  // entry fraction comes from the divider
        logic need_max;  // exit fraction comes from the divider
    } t_axis_ctl;

endpackage

// ----- hw/rtl/sbsi_prep.sv -----
// sbsi_prep: one axis of the slab test setup, registered
// produces rejection, direction and divider operands; uses sbsi_pkg
module sbsi_prep #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_beg,
    input  logic        [COORD_WIDTH-2:0] i_size,
    input  logic signed [COORD_WIDTH-1:0] i_from,
    input  logic signed [COORD_WIDTH-1:0] i_to,
    output sbsi_pkg::t_axis_ctl           o_ctl,
    output logic        [COORD_WIDTH-1:0] o_num_min,
    output logic        [COORD_WIDTH-1:0] o_num_max,
    output logic        [COORD_WIDTH-1:0] o_den
);
    import sbsi_pkg::*;

    localparam int XW = COORD_WIDTH + 2;

    logic signed [XW-1:0] b2, e2, f2, t2;
    logic signed [XW-1:0] len2, nmin2, nmax2;
    logic                 pos;
    t_axis_ctl            ctl;

    always_comb begin
        b2 = XW'(i_beg);
        f2 = XW'(i_from);
        t2 = XW'(i_to);
        e2 = b2 + signed'({2'b00, 1'b0, i_size});
        pos = f2 < t2;
        ctl.dir_pos = pos;
        if (pos) begin
            ctl.reject   = (f2 > e2) || (t2 < b2);
            len2         = t2 - f2;
            nmin2        = b2 - f2;
            ctl.need_min = f2 < b2;
            nmax2        = e2 - f2;
            ctl.need_max = t2 > e2;
        end else begin
            ctl.reject   = (t2 > e2) || (f2 < b2);
            len2         = f2 - t2;
            nmin2        = f2 - e2;
            ctl.need_min = f2 > e2;
            nmax2        = f2 - b2;
            ctl.need_max = t2 < b2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl     <= ctl;
            o_num_min <= ctl.need_min ? COORD_WIDTH'(nmin2) : '0;
            o_num_max <= ctl.need_max ? COORD_WIDTH'(nmax2) : '0;
            // zero length only on a degenerate axis, whose fractions are not used
            o_den     <= (len2 == '0) ? COORD_WIDTH'(1) : COORD_WIDTH'(len2);
        end
    end

endmodule

// ----- hw/rtl/sbsi_div.sv -----
// sbsi_div: pipelined restoring fraction divider, one quotient bit per stage
// floor(num * 2^FRAC_BITS / den) for num <= den; uses sbsi_pkg
module sbsi_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [COORD_WIDTH-1:0] i_num,
    input  logic [COORD_WIDTH-1:0] i_den,
    output logic [FRAC_BITS:0]     o_quo
);
    import sbsi_pkg::*;

    localparam int N = COORD_WIDTH;
    localparam int S = FRAC_BITS + 1;

    logic [N:0]         r_rem [S];
    logic [N-1:0]       r_den [S];
    logic [FRAC_BITS:0] r_quo [S];

    for (genvar k = 0; k < S; k++) begin : g_step
        logic [N:0]         rem_in;
        logic [N-1:0]       den_in;
        logic [FRAC_BITS:0] quo_in;
        logic               ge;
        if (k == 0) begin : g_first
            assign rem_in = {1'b0, i_num};
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            // remainder stays below den, so its top bit is always clear
            assign rem_in = {r_rem[k-1][N-1:0], 1'b0};
            assign den_in = r_den[k-1];
            assign quo_in = {r_quo[k-1][FRAC_BITS-1:0], 1'b0};
        end
        assign ge = rem_in >= {1'b0, den_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (rem_in - {1'b0, den_in}) : rem_in;
                r_den[k] <= den_in;
                r_quo[k] <= quo_in | (FRAC_BITS + 1)'(ge);
            end
        end
    end

    assign o_quo = r_quo[S-1];

endmodule

// ----- hw/rtl/sbsi_hit.sv -----
// sbsi_hit: interval merge, hit point scaling and saturation, three stages
// takes divider quotients and per axis control; uses sbsi_pkg
module sbsi_hit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  sbsi_pkg::t_axis_ctl           i_ctl_x,
    input  sbsi_pkg::t_axis_ctl           i_ctl_y,
    input  logic        [FRAC_BITS:0]     i_qmin_x,
    input  logic        [FRAC_BITS:0]     i_qmax_x,
    input  logic        [FRAC_BITS:0]     i_qmin_y,
    input  logic        [FRAC_BITS:0]     i_qmax_y,
    input  logic signed [COORD_WIDTH-1:0] i_from_x,
    input  logic signed [COORD_WIDTH-1:0] i_from_y,
    input  logic signed [COORD_WIDTH-1:0] i_to_x,
    input  logic signed [COORD_WIDTH-1:0] i_to_y,
    output logic                          o_hit,
    output logic        [FRAC_BITS:0]     o_frac,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y,
    output logic        [1:0]             o_normal_x,
    output logic        [1:0]             o_normal_y
);
    import sbsi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int TW = FRAC_BITS + 1;
    localparam int MW = W + 1;
    localparam int PW = MW + TW;
    localparam int SW = W + 3;
    localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

    // stage 1: merge intervals
    logic [TW-1:0]       cmin_x, cmax_x, cmin_y, cmax_y, tmin, tmax;
    logic                upd_x, upd_y, miss;
    logic [1:0]          nx, ny;
    logic signed [MW-1:0] rel_x, rel_y;

    always_comb begin
        cmin_x = i_ctl_x.need_min ? i_qmin_x : '0;
        cmax_x = i_ctl_x.need_max ? i_qmax_x : T_ONE;
        cmin_y = i_ctl_y.need_min ? i_qmin_y : '0;
        cmax_y = i_ctl_y.need_max ? i_qmax_y : T_ONE;
        upd_x  = cmin_x != '0;
        upd_y  = cmin_y > cmin_x;
        tmin   = upd_y ? cmin_y : cmin_x;
        tmax   = (cmax_y < cmax_x) ? cmax_y : cmax_x;
        miss   = i_ctl_x.reject || i_ctl_y.reject || (tmax < tmin);
        nx     = NRM_ZERO;
        ny     = NRM_ZERO;
        if (upd_y) begin
            ny = i_ctl_y.dir_pos ? NRM_NEG : NRM_POS;
        end else if (upd_x) begin
            nx = i_ctl_x.dir_pos ? NRM_NEG : NRM_POS;
        end
        rel_x = MW'(i_to_x) - MW'(i_from_x);
        rel_y = MW'(i_to_y) - MW'(i_from_y);
    end

    logic                r1_hit, r1_neg_x, r1_neg_y;
    logic [TW-1:0]       r1_tmin;
    logic [1:0]          r1_nx, r1_ny;
    logic [MW-1:0]       r1_mag_x, r1_mag_y;
    logic signed [W-1:0] r1_fx, r1_fy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hit   <= !miss;
            r1_tmin  <= tmin;
            r1_nx    <= nx;
            r1_ny    <= ny;
            r1_neg_x <= rel_x[MW-1];
            r1_neg_y <= rel_y[MW-1];
            r1_mag_x <= rel_x[MW-1] ? MW'(-rel_x) : MW'(rel_x);
            r1_mag_y <= rel_y[MW-1] ? MW'(-rel_y) : MW'(rel_y);
            r1_fx    <= i_from_x;
            r1_fy    <= i_from_y;
        end
    end

    // stage 2: scale offsets
    logic                r2_hit, r2_neg_x, r2_neg_y;
    logic [TW-1:0]       r2_tmin;
    logic [1:0]          r2_nx, r2_ny;
    logic [PW-1:0]       r2_prod_x, r2_prod_y;
    logic signed [W-1:0] r2_fx, r2_fy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_hit    <= r1_hit;
            r2_tmin   <= r1_tmin;
            r2_nx     <= r1_nx;
            r2_ny     <= r1_ny;
            r2_neg_x  <= r1_neg_x;
            r2_neg_y  <= r1_neg_y;
            r2_prod_x <= PW'(r1_mag_x) * PW'(r1_tmin);
            r2_prod_y <= PW'(r1_mag_y) * PW'(r1_tmin);
            r2_fx     <= r1_fx;
            r2_fy     <= r1_fy;
        end
    end

    // stage 3: add to start point and saturate
    localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(W - 1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [SW-1:0] off_x, off_y, sum_x, sum_y;
    logic signed [W-1:0]  sat_x, sat_y;

    always_comb begin
        off_x = SW'(r2_prod_x >> FRAC_BITS);
        off_y = SW'(r2_prod_y >> FRAC_BITS);
        if (r2_neg_x) off_x = -off_x;
        if (r2_neg_y) off_y = -off_y;
        sum_x = SW'(r2_fx) + off_x;
        sum_y = SW'(r2_fy) + off_y;
        sat_x = (sum_x > SAT_HI) ? W'(SAT_HI) : (sum_x < SAT_LO) ? W'(SAT_LO) : W'(sum_x);
        sat_y = (sum_y > SAT_HI) ? W'(SAT_HI) : (sum_y < SAT_LO) ? W'(SAT_LO) : W'(sum_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit      <= r2_hit;
            o_frac     <= r2_hit ? r2_tmin : '0;
            o_hit_x    <= r2_hit ? sat_x : '0;
            o_hit_y    <= r2_hit ? sat_y : '0;
            o_normal_x <= r2_hit ? r2_nx : NRM_ZERO;
            o_normal_y <= r2_hit ? r2_ny : NRM_ZERO;
        end
    end

endmodule

// ----- hw/rtl/segment_box_slab_intersect_top.sv -----
// segment_box_slab_intersect_top: 2d slab test of a segment against a box
// a transfer passes the prep, divider and hit stages in that order to the result
// throughput one item per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// the whole pipeline holds while a result waits and the output is not taken
// synchronous active-low reset clears the valid bits; data registers keep values
// depends on sbsi_pkg, sbsi_prep, sbsi_div, sbsi_hit
module segment_box_slab_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // fields from bit 0: box_x, box_y, box_w, box_h, from_x, from_y, to_x, to_y
    input  logic [((6 * COORD_WIDTH + 2 * (COORD_WIDTH - 1) + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // fields from bit 0: entry_fraction, hit_x, hit_y, normal_x, normal_y
    output logic [((FRAC_BITS + 1 + 2 * COORD_WIDTH + 4 + 7) / 8) * 8 - 1:0] o_m_tdata,
    // fields from bit 0: hit
    output logic o_m_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready
);
    import sbsi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int TW  = FRAC_BITS + 1;
    localparam int DS  = FRAC_BITS + 1;   // divider stages
    localparam int LAT = FRAC_BITS + 5;
    localparam int OUT_BITS = ((TW + 2 * W + 4 + 7) / 8) * 8;

    // input field offsets
    localparam int O_BY = W;
    localparam int O_BW = 2 * W;
    localparam int O_BH = 3 * W - 1;
    localparam int O_FX = 4 * W - 2;
    localparam int O_FY = 5 * W - 2;
    localparam int O_TX = 6 * W - 2;
    localparam int O_TY = 7 * W - 2;

    // one global enable: every stage moves when the output slot is free or taken
    logic en, accept;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;
    assign accept     = i_s_tvalid && en;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end
    assign o_m_tvalid = r_vld[LAT-1];

    // field split
    logic signed [W-1:0] box_x, box_y, from_x, from_y, to_x, to_y;
    logic [W-2:0]        box_w, box_h;
    assign box_x  = i_s_tdata[W-1:0];
    assign box_y  = i_s_tdata[O_BY +: W];
    assign box_w  = i_s_tdata[O_BW +: W-1];
    assign box_h  = i_s_tdata[O_BH +: W-1];
    assign from_x = i_s_tdata[O_FX +: W];
    assign from_y = i_s_tdata[O_FY +: W];
    assign to_x   = i_s_tdata[O_TX +: W];
    assign to_y   = i_s_tdata[O_TY +: W];

    // prep stage, one instance per axis
    t_axis_ctl        ctl_x, ctl_y;
    logic [W-1:0]     nmin_x, nmax_x, den_x, nmin_y, nmax_y, den_y;

    sbsi_prep #(.COORD_WIDTH(W)) u_prep_x (
        .i_clk(i_clk), .i_en(en), .i_beg(box_x), .i_size(box_w),
        .i_from(from_x), .i_to(to_x), .o_ctl(ctl_x),
        .o_num_min(nmin_x), .o_num_max(nmax_x), .o_den(den_x)
    );
    sbsi_prep #(.COORD_WIDTH(W)) u_prep_y (
        .i_clk(i_clk), .i_en(en), .i_beg(box_y), .i_size(box_h),
        .i_from(from_y), .i_to(to_y), .o_ctl(ctl_y),
        .o_num_min(nmin_y), .o_num_max(nmax_y), .o_den(den_y)
    );

    // four dividers: entry and exit fraction on each axis
    logic [TW-1:0] qmin_x, qmax_x, qmin_y, qmax_y;

    sbsi_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_min_x (
        .i_clk(i_clk), .i_en(en), .i_num(nmin_x), .i_den(den_x), .o_quo(qmin_x)
    );
    sbsi_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_max_x (
        .i_clk(i_clk), .i_en(en), .i_num(nmax_x), .i_den(den_x), .o_quo(qmax_x)
    );
    sbsi_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_min_y (
        .i_clk(i_clk), .i_en(en), .i_num(nmin_y), .i_den(den_y), .o_quo(qmin_y)
    );
    sbsi_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_max_y (
        .i_clk(i_clk), .i_en(en), .i_num(nmax_y), .i_den(den_y), .o_quo(qmax_y)
    );

    // side data delay lines, aligned with the divider outputs
    logic [4*W-1:0]  r_pts [DS+1];
    t_axis_ctl [1:0] r_ctl [DS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pts[0] <= {to_y, to_x, from_y, from_x};
            for (int k = 1; k <= DS; k++) r_pts[k] <= r_pts[k-1];
            r_ctl[0] <= {ctl_y, ctl_x};
            for (int k = 1; k < DS; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    // merge, scale, saturate
    logic                hit;
    logic [TW-1:0]       frac;
    logic signed [W-1:0] hit_x, hit_y;
    logic [1:0]          nrm_x, nrm_y;

    sbsi_hit #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_hit (
        .i_clk(i_clk), .i_en(en),
        .i_ctl_x(r_ctl[DS-1][0]), .i_ctl_y(r_ctl[DS-1][1]),
        .i_qmin_x(qmin_x), .i_qmax_x(qmax_x), .i_qmin_y(qmin_y), .i_qmax_y(qmax_y),
        .i_from_x(r_pts[DS][W-1:0]), .i_from_y(r_pts[DS][2*W-1:W]),
        .i_to_x(r_pts[DS][3*W-1:2*W]), .i_to_y(r_pts[DS][4*W-1:3*W]),
        .o_hit(hit), .o_frac(frac), .o_hit_x(hit_x), .o_hit_y(hit_y),
        .o_normal_x(nrm_x), .o_normal_y(nrm_y)
    );

    assign o_m_tdata = OUT_BITS'({nrm_y, nrm_x, hit_y, hit_x, frac});
    assign o_m_tuser = hit;

endmodule

// ----- hw/rtl/sbsi_checker.sv -----
// sbsi_checker: port-level assertions for the slab intersect block, with bind
// depends on segment_box_slab_intersect_top port list
module sbsi_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic [((FRAC_BITS + 1 + 2 * COORD_WIDTH + 4 + 7) / 8) * 8 - 1:0] o_m_tdata,
    input logic o_m_tuser,
    input logic o_m_tvalid,
    input logic i_m_tready
);
    localparam int TW = FRAC_BITS + 1;
    localparam int ONX = TW + 2 * COORD_WIDTH;

    logic [TW-1:0] frac;
    logic [1:0]    nx, ny;
    assign frac = o_m_tdata[TW-1:0];
    assign nx   = o_m_tdata[ONX +: 2];
    assign ny   = o_m_tdata[ONX + 2 +: 2];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss result not cleared");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> frac <= (TW'(1) << FRAC_BITS))
        else $error("entry fraction above one");

    a_one_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(nx != 2'b00 && ny != 2'b00) && nx != 2'b10 && ny != 2'b10)
        else $error("bad normal");

endmodule

bind segment_box_slab_intersect_top sbsi_checker #(
    .COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_sbsi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_m_tdata(o_m_tdata),
    .o_m_tuser(o_m_tuser), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready)
);
